[rtl/core/prt_pkg.sv]
// ----------------------------------------------------------------------------
// prt_pkg
// Shared constants and a mask helper for the prefix rule table.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [7:0] V4_MAX_LEN = 8'd32;
    localparam logic [7:0] V6_MAX_LEN = 8'd128;

    localparam logic [1:0] REG_MIN_RATE = 2'd0;
    localparam logic [1:0] REG_MAX_RATE = 2'd1;
    localparam logic [1:0] REG_MIN_GAIN = 2'd2;
    localparam logic [1:0] REG_MAX_GAIN = 2'd3;

    localparam int PADDR_W = 5;

    // top n bits of a 64-bit word
    function automatic logic [63:0] top_mask(input logic [7:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 64; k++) begin
            if (32'(k) < 32'(n)) begin
                m[63-k] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

[rtl/core/prefix_rule_table_lpm.sv]
// ----------------------------------------------------------------------------
// prefix_rule_table_lpm
// Longest-prefix rule table for IPv4 and IPv6 with add, delete and flush.
// Lookup, add and delete pass through the read, scan and write states before
// o_valid; flush goes straight to the write state. The scan reads one entry a cycle.
// A new item is accepted only once the last result has been taken and the block
// is back in idle; input stays blocked while a result waits.
// Reset clears the valid bits and the id counter and restores the limit defaults.
// ----------------------------------------------------------------------------
module prefix_rule_table_lpm
    import prt_pkg::*;
#(
    parameter int RULES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_action,
    input  logic                 i_is_v6,
    input  logic [63:0]          i_addr_hi,
    input  logic [63:0]          i_addr_lo,
    input  logic [7:0]           i_prefix_len,
    input  logic [63:0]          i_rate,
    input  logic [15:0]          i_gain,
    input  logic                 i_lock_flag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic                 o_hit,
    output logic [31:0]          o_group_id,
    output logic [63:0]          o_match_rate,
    output logic [15:0]          o_match_gain,
    output logic                 o_match_locked,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CW = $clog2(RULES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    typedef struct packed {
        logic        is_v6;
        logic [7:0]  plen;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] gid;
        logic [63:0] rate;
        logic [15:0] gain;
        logic        lock;
    } t_entry;

    logic [63:0] r_min_rate, r_max_rate;
    logic [15:0] r_min_gain, r_max_gain;

    t_entry      r_mem [RULES];
    t_entry      r_rd;
    logic [RULES-1:0] r_vld;
    logic [31:0] r_next_id;

    logic [2:0]  r_state;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_rd_slot;
    logic        r_rd_ok;

    logic [1:0]  r_act;
    logic        r_v6;
    logic [63:0] r_hi, r_lo;
    logic [7:0]  r_plen;
    logic [63:0] r_rate;
    logic [15:0] r_gain;
    logic        r_lock;

    logic        r_found;
    logic [IW-1:0] r_slot;
    logic [31:0] r_slot_gid;
    logic        r_free_ok;
    logic [IW-1:0] r_free;
    logic        r_best_ok;
    logic [7:0]  r_best_len;
    logic [31:0] r_best_gid;
    logic [63:0] r_best_rate;
    logic [15:0] r_best_gain;
    logic        r_best_lock;

    logic [1:0]  r_status;
    logic        r_hit;
    logic [31:0] r_gid_out;
    logic        r_ovalid;

    logic        in_fire, cfg_wr;
    logic [1:0]  cfg_idx;
    logic [63:0] mh, ml, m4;
    logic        match, key_eq, better;
    logic        bad_len, bad_lim;
    logic [63:0] in_hi, in_lo;
    logic        in_v6;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];
    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        case (cfg_idx)
            REG_MIN_RATE: prdata = r_min_rate;
            REG_MAX_RATE: prdata = r_max_rate;
            REG_MIN_GAIN: prdata = {48'd0, r_min_gain};
            REG_MAX_GAIN: prdata = {48'd0, r_max_gain};
            default:      prdata = '0;
        endcase
    end

    // normalize the incoming key; lookups fold v4-mapped v6 into v4
    always_comb begin
        in_v6 = i_is_v6;
        in_hi = i_is_v6 ? i_addr_hi : 64'd0;
        in_lo = i_is_v6 ? i_addr_lo : {32'd0, i_addr_lo[31:0]};
        if (i_action == ACT_LOOKUP && i_is_v6 && i_addr_hi == 64'd0 &&
            i_addr_lo[63:32] == 32'h0000_FFFF) begin
            in_v6 = 1'b0;
            in_lo = {32'd0, i_addr_lo[31:0]};
        end
    end

    always_comb begin
        mh = top_mask((r_rd.plen > 8'd64) ? 8'd64 : r_rd.plen);
        ml = top_mask((r_rd.plen > 8'd64) ? (r_rd.plen - 8'd64) : 8'd0);
        m4 = top_mask((r_rd.plen > 8'd32) ? 8'd32 : r_rd.plen);
        if (r_v6) begin
            match = (((r_hi ^ r_rd.hi) & mh) == 64'd0) &&
                    (((r_lo ^ r_rd.lo) & ml) == 64'd0);
        end else begin
            match = (((r_lo[31:0] ^ r_rd.lo[31:0]) & m4[63:32]) == 32'd0);
        end
        match  = match && r_rd_ok && (r_rd.is_v6 == r_v6);
        key_eq = r_rd_ok && (r_rd.is_v6 == r_v6) && (r_rd.plen == r_plen) &&
                 (r_rd.hi == r_hi) && (r_rd.lo == r_lo);
        better = !r_best_ok || (r_rd.plen > r_best_len) ||
                 (r_rd.plen == r_best_len && r_rd.gid < r_best_gid);
        bad_len = r_plen > (r_v6 ? V6_MAX_LEN : V4_MAX_LEN);
        bad_lim = (r_rate < r_min_rate) || (r_rate > r_max_rate) ||
                  (r_gain < r_min_gain) || (r_gain > r_max_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= '0;
            r_max_rate <= '1;
            r_min_gain <= '0;
            r_max_gain <= '1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MIN_RATE: r_min_rate <= pwdata;
                REG_MAX_RATE: r_max_rate <= pwdata;
                REG_MIN_GAIN: r_min_gain <= pwdata[15:0];
                REG_MAX_GAIN: r_max_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // entry memory: one read port feeding the scan, one write port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx[IW-1:0]];
        if (r_state == S_WRITE && r_act == ACT_ADD && !bad_len && !bad_lim) begin
            if (r_found) begin
                r_mem[r_slot].rate <= r_rate;
                r_mem[r_slot].gain <= r_gain;
                r_mem[r_slot].lock <= r_lock;
            end else if (r_free_ok) begin
                r_mem[r_free] <= '{r_v6, r_plen, r_hi, r_lo, r_next_id + 32'd1,
                                   r_rate, r_gain, r_lock};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act  <= i_action;
            r_v6   <= in_v6;
            r_hi   <= in_hi;
            r_lo   <= in_lo;
            r_plen <= i_prefix_len;
            r_rate <= i_rate;
            r_gain <= i_gain;
            r_lock <= i_lock_flag;
        end
        r_rd_slot <= r_idx[IW-1:0];
        if (r_state == S_SCAN) begin
            if (match && better) begin
                r_best_len  <= r_rd.plen;
                r_best_gid  <= r_rd.gid;
                r_best_rate <= r_rd.rate;
                r_best_gain <= r_rd.gain;
                r_best_lock <= r_rd.lock;
            end
            if (key_eq && !r_found) begin
                r_slot     <= r_rd_slot;
                r_slot_gid <= r_rd.gid;
            end
            if (!r_rd_ok && !r_free_ok) begin
                r_free <= r_rd_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_next_id <= '0;
            r_idx     <= '0;
            r_rd_ok   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
            r_status  <= ST_OK;
            r_hit     <= 1'b0;
            r_gid_out <= '0;
        end else begin
            r_rd_ok <= r_vld[r_idx[IW-1:0]];
            if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_state   <= (i_action == ACT_FLUSH) ? S_WRITE : S_READ;
                    end
                end
                S_READ: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (match && better) r_best_ok <= 1'b1;
                    if (key_eq) r_found <= 1'b1;
                    if (!r_rd_ok) r_free_ok <= 1'b1;
                    if (r_idx == CW'(RULES)) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_WRITE: begin
                    r_status  <= ST_OK;
                    r_hit     <= 1'b0;
                    r_gid_out <= '0;
                    case (r_act)
                        ACT_LOOKUP: begin
                            r_hit     <= r_best_ok;
                            r_gid_out <= r_best_ok ? r_best_gid : 32'd0;
                        end
                        ACT_FLUSH: r_vld <= '0;
                        ACT_DELETE: begin
                            if (bad_len) r_status <= ST_INVALID;
                            else if (!r_found) r_status <= ST_NOTFOUND;
                            else r_vld[r_slot] <= 1'b0;
                        end
                        ACT_ADD: begin
                            if (bad_len || bad_lim) begin
                                r_status <= ST_INVALID;
                            end else if (r_found) begin
                                r_gid_out <= r_slot_gid;
                            end else if (!r_free_ok) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_vld[r_free] <= 1'b1;
                                r_next_id     <= r_next_id + 32'd1;
                                r_gid_out     <= r_next_id + 32'd1;
                            end
                        end
                        default: ;
                    endcase
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_group_id     = r_gid_out;
    assign o_match_rate   = r_hit ? r_best_rate : 64'd0;
    assign o_match_gain   = r_hit ? r_best_gain : 16'd0;
    assign o_match_locked = r_hit && r_best_lock;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_status == ST_OK))
        else $error("hit with bad status");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped");

endmodule
